// ===== src/ete_pkg.sv =====
// Shared types, constants and the arctangent table for the equatorial to
// horizontal converter. No dependencies.
package ete_pkg;

   localparam int DEF_ANGLE_BITS = 32;

   localparam int ROT_W       = 34;
   localparam int VEC_W       = 46;
   localparam int AT_IN_W     = 34;
   localparam int SQ_W        = 61;
   localparam int ROT_STAGES  = 30;
   localparam int VEC_STAGES  = 32;
   localparam int SQRT_STAGES = 31;
   localparam int NORM_STEPS  = 7;
   localparam int SC_LAT      = ROT_STAGES + 2;
   localparam int AT_LAT      = 1 + NORM_STEPS + VEC_STAGES;

   localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;
   localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
   localparam logic [31:0] QUARTER_ANG     = 32'h4000_0000;
   localparam logic [31:0] NEG_QUARTER_ANG = 32'hC000_0000;
   localparam logic [31:0] HALF_ANG        = 32'h8000_0000;

   typedef enum logic [1:0] {
      SPEC_NONE = 2'd0,
      SPEC_ZERO = 2'd1,
      SPEC_POS  = 2'd2,
      SPEC_NEG  = 2'd3
   } spec_type;

   typedef struct packed {
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [ROT_W-1:0] z;
      logic                    neg;
      spec_type                spec;
   } rot_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic [31:0]             z;
   } vec_type;

   typedef struct packed {
      logic [SQ_W-1:0] v;
      logic [SQ_W-1:0] res;
   } sqrt_type;

   function automatic logic [31:0] atan_angle(input int i);
      logic [31:0] a;
      case (i)
         0:  a = 32'h20000000;  1:  a = 32'h12E4051E;  2:  a = 32'h09FB385B;
         3:  a = 32'h051111D4;  4:  a = 32'h028B0D43;  5:  a = 32'h0145D7E1;
         6:  a = 32'h00A2F61E;  7:  a = 32'h00517C55;  8:  a = 32'h0028BE53;
         9:  a = 32'h00145F2F;  10: a = 32'h000A2F98;  11: a = 32'h000517CC;
         12: a = 32'h00028BE6;  13: a = 32'h000145F3;  14: a = 32'h0000A2FA;
         15: a = 32'h0000517D;  16: a = 32'h000028BE;  17: a = 32'h0000145F;
         18: a = 32'h00000A30;  19: a = 32'h00000518;  20: a = 32'h0000028C;
         21: a = 32'h00000146;  22: a = 32'h000000A3;  23: a = 32'h00000051;
         24: a = 32'h00000029;  25: a = 32'h00000014;  26: a = 32'h0000000A;
         27: a = 32'h00000005;  28: a = 32'h00000003;  29: a = 32'h00000001;
         30: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

// ===== src/ete_rot_cell.sv =====
// One rotation CORDIC micro-rotation with its output register.
// Depends on ete_pkg.
module ete_rot_cell #(
   parameter int STAGE = 0
) (
   input  logic            clock,
   input  logic            en,
   input  ete_pkg::rot_type d,
   output ete_pkg::rot_type q
);
   import ete_pkg::*;

   localparam logic signed [ROT_W-1:0] ANG = $signed({{(ROT_W-32){1'b0}}, atan_angle(STAGE)});

   rot_type q_ff, q_in;
   logic signed [ROT_W-1:0] x, y, z, xs, ys;

   always_comb begin
      x  = d.x;
      y  = d.y;
      z  = d.z;
      xs = x >>> STAGE;
      ys = y >>> STAGE;
      q_in = d;
      if (!z[ROT_W-1]) begin
         q_in.x = x - ys;
         q_in.y = y + xs;
         q_in.z = z - ANG;
      end else begin
         q_in.x = x + ys;
         q_in.y = y - xs;
         q_in.z = z + ANG;
      end
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign q = q_ff;
endmodule

// ===== src/ete_sincos.sv =====
// Sine and cosine of a 32-bit binary angle: fold, chain of rotation cells,
// clamp and sign fix. Depends on ete_pkg and ete_rot_cell.
module ete_sincos (
   input  logic                clock,
   input  logic                en,
   input  logic [31:0]         angle,
   output logic signed [31:0]  cos_q,
   output logic signed [31:0]  sin_q
);
   import ete_pkg::*;

   localparam logic signed [ROT_W-1:0] QTR  = ROT_W'(64'sd1073741824);
   localparam logic signed [ROT_W-1:0] HALF = ROT_W'(64'sd2147483648);

   rot_type chain [0:ROT_STAGES];
   rot_type fold_ff, fold_in;
   logic signed [ROT_W-1:0] z0;
   logic signed [31:0] cos_ff, sin_ff, cos_in, sin_in;
   logic signed [ROT_W-1:0] xe, ye;

   always_comb begin
      z0 = ROT_W'($signed(angle));
      fold_in.neg = 1'b0;
      if (z0 > QTR) begin
         z0 = z0 - HALF;
         fold_in.neg = 1'b1;
      end else if (z0 < -QTR) begin
         z0 = z0 + HALF;
         fold_in.neg = 1'b1;
      end
      fold_in.x = ROT_W'(GAIN_Q30);
      fold_in.y = '0;
      fold_in.z = z0;
      if (z0 == 0) fold_in.spec = SPEC_ZERO;
      else if (z0 == QTR) fold_in.spec = SPEC_POS;
      else if (z0 == -QTR) fold_in.spec = SPEC_NEG;
      else fold_in.spec = SPEC_NONE;
   end

   always_ff @(posedge clock) begin
      if (en) fold_ff <= fold_in;
   end

   assign chain[0] = fold_ff;

   for (genvar i = 0; i < ROT_STAGES; i++) begin : g_cell
      ete_rot_cell #(.STAGE(i)) u_cell (
         .clock (clock),
         .en    (en),
         .d     (chain[i]),
         .q     (chain[i+1])
      );
   end

   always_comb begin
      xe = chain[ROT_STAGES].x;
      ye = chain[ROT_STAGES].y;
      if (xe > ROT_W'(ONE_Q30)) xe = ROT_W'(ONE_Q30);
      if (xe < -ROT_W'(ONE_Q30)) xe = -ROT_W'(ONE_Q30);
      if (ye > ROT_W'(ONE_Q30)) ye = ROT_W'(ONE_Q30);
      if (ye < -ROT_W'(ONE_Q30)) ye = -ROT_W'(ONE_Q30);
      case (chain[ROT_STAGES].spec)
         SPEC_ZERO: begin cos_in = ONE_Q30; sin_in = '0;       end
         SPEC_POS:  begin cos_in = '0;      sin_in = ONE_Q30;  end
         SPEC_NEG:  begin cos_in = '0;      sin_in = -ONE_Q30; end
         default:   begin cos_in = xe[31:0]; sin_in = ye[31:0]; end
      endcase
      if (chain[ROT_STAGES].neg) begin
         cos_in = -cos_in;
         sin_in = -sin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_q = cos_ff;
   assign sin_q = sin_ff;
endmodule

// ===== src/ete_sqrt_cell.sv =====
// One digit of the integer floor square root, with its output register.
// Depends on ete_pkg.
module ete_sqrt_cell #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  logic              en,
   input  ete_pkg::sqrt_type d,
   output ete_pkg::sqrt_type q
);
   import ete_pkg::*;

   localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 1 - 2 * STAGE);

   sqrt_type q_ff, q_in;
   logic [SQ_W-1:0] trial;

   always_comb begin
      trial = d.res + BIT;
      if (d.v >= trial) begin
         q_in.v   = d.v - trial;
         q_in.res = (d.res >> 1) + BIT;
      end else begin
         q_in.v   = d.v;
         q_in.res = d.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign q = q_ff;
endmodule

// ===== src/ete_vec_cell.sv =====
// One vectoring CORDIC micro-rotation with its output register.
// Depends on ete_pkg.
module ete_vec_cell #(
   parameter int STAGE = 0
) (
   input  logic             clock,
   input  logic             en,
   input  ete_pkg::vec_type d,
   output ete_pkg::vec_type q
);
   import ete_pkg::*;

   localparam logic [31:0] ANG = atan_angle(STAGE);

   vec_type q_ff, q_in;
   logic signed [VEC_W-1:0] x, y, xs, ys;

   always_comb begin
      x  = d.x;
      y  = d.y;
      xs = x >>> STAGE;
      ys = y >>> STAGE;
      if (!y[VEC_W-1] && (y != 0)) begin
         q_in.x = x + ys;
         q_in.y = y - xs;
         q_in.z = d.z + ANG;
      end else begin
         q_in.x = x - ys;
         q_in.y = y + xs;
         q_in.z = d.z - ANG;
      end
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign q = q_ff;
endmodule

// ===== src/ete_atan2.sv =====
// Four-quadrant arctangent: half-plane fold, staged normalize shift, chain
// of vectoring cells. Depends on ete_pkg and ete_vec_cell.
module ete_atan2 (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [ete_pkg::AT_IN_W-1:0] x,
   input  logic signed [ete_pkg::AT_IN_W-1:0] y,
   output logic [31:0]                        angle
);
   import ete_pkg::*;

   vec_type pre_ff, pre_in;
   vec_type norm [0:NORM_STEPS];
   vec_type chain [0:VEC_STAGES];
   logic zf_ff [0:AT_LAT-1];
   logic signed [VEC_W-1:0] xw, yw;

   always_comb begin
      xw = VEC_W'(x);
      yw = VEC_W'(y);
      pre_in.z = '0;
      if (xw[VEC_W-1]) begin
         xw = -xw;
         yw = -yw;
         pre_in.z = HALF_ANG;
      end
      pre_in.x = xw;
      pre_in.y = yw;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_ff   <= pre_in;
         zf_ff[0] <= (x == 0) && (y == 0);
         for (int i = 1; i < AT_LAT; i++) zf_ff[i] <= zf_ff[i-1];
      end
   end

   assign norm[0] = pre_ff;

   for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
      localparam int K   = (j < NORM_STEPS - 1) ? (32 >> j) : 1;
      localparam int LIM = (j < NORM_STEPS - 1) ? (40 - K) : 40;
      localparam logic [VEC_W-1:0] BOUND = VEC_W'(1) << LIM;
      vec_type n_ff, n_in;
      logic [VEC_W-1:0] ax, ay;
      always_comb begin
         ax = norm[j].x[VEC_W-1] ? VEC_W'(-norm[j].x) : VEC_W'(norm[j].x);
         ay = norm[j].y[VEC_W-1] ? VEC_W'(-norm[j].y) : VEC_W'(norm[j].y);
         n_in = norm[j];
         if ((ax < BOUND) && (ay < BOUND)) begin
            n_in.x = norm[j].x <<< K;
            n_in.y = norm[j].y <<< K;
         end
      end
      always_ff @(posedge clock) begin
         if (en) n_ff <= n_in;
      end
      assign norm[j+1] = n_ff;
   end

   assign chain[0] = norm[NORM_STEPS];

   for (genvar i = 0; i < VEC_STAGES; i++) begin : g_cell
      ete_vec_cell #(.STAGE(i)) u_cell (
         .clock (clock),
         .en    (en),
         .d     (chain[i]),
         .q     (chain[i+1])
      );
   end

   assign angle = zf_ff[AT_LAT-1] ? 32'h0 : chain[VEC_STAGES].z;
endmodule

// ===== src/equatorial_to_horizontal.sv =====
// Equatorial to horizontal conversion, top level. Depends on ete_pkg,
// ete_sincos, ete_sqrt_cell and ete_atan2.
// An accepted request word passes through 32 sine/cosine stages, 5 product
// stages, 31 root cells, 40 arctangent stages and the output register to its
// response word. Throughput: one word per cycle; the whole pipeline holds
// while a response waits. Reset clears the valid pipeline and the latitude.
module equatorial_to_horizontal #(
   parameter int ANGLE_BITS = ete_pkg::DEF_ANGLE_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_we,
   input  logic [ANGLE_BITS-1:0]                     csr_wdata,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // right_ascension, declination, sidereal_time
   input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]         req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // azimuth, elevation
   output logic [((2*ANGLE_BITS+7)/8)*8-1:0]         rsp_tdata,
   // degenerate
   output logic [0:0]                                rsp_tuser
);
   import ete_pkg::*;

   localparam int AB      = ANGLE_BITS;
   localparam int RSP_W   = ((2 * AB + 7) / 8) * 8;
   localparam int LATENCY = SC_LAT + 5 + SQRT_STAGES + AT_LAT + 1;

   typedef struct packed {
      logic signed [31:0] se;
      logic               cl_zero;
      logic signed [31:0] num;
      logic signed [33:0] den;
   } side_type;

   typedef struct packed {
      logic ce_zero;
      logic se_pos;
      logic degen;
   } flag_type;

   function automatic logic [31:0] to32(input logic [AB-1:0] a);
      logic [AB+63:0] w;
      w = {a, 64'h0};
      return w[AB+63 -: 32];
   endfunction

   function automatic logic [AB-1:0] from32(input logic [31:0] a);
      logic [95:0] w;
      w = {a, 64'h0};
      return w[95 -: AB];
   endfunction

   function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p[61:30];
   endfunction

   logic en;
   logic [LATENCY-1:0] vld_ff, vld_in;
   logic [AB-1:0] lat_ff;

   logic [31:0] ra32, dec32, lst32, ha32;
   logic signed [31:0] cl, sl, cd, sd, ch, sh;

   logic signed [31:0] m1_p1_ff, m1_p2_ff, m1_q1_ff, m1_sl_ff, m1_cl_ff, m1_sd_ff;
   logic signed [31:0] m2_p1_ff, m2_p3_ff, m2_numr_ff, m2_sl_ff, m2_cl_ff, m2_sd_ff;
   logic signed [31:0] m3_se_ff, m3_num_ff, m3_sl_ff, m3_cl_ff, m3_sd_ff, m3_se_in;
   logic signed [32:0] sum_se;
   logic [SQ_W-1:0]    m4_sq_ff;
   logic signed [31:0] m4_t_ff, m4_se_ff, m4_cl_ff, m4_sd_ff, m4_num_ff;
   logic signed [63:0] se_sq;
   logic signed [31:0] abs_cl;
   logic signed [33:0] den_in;

   sqrt_type m5_ff, m5_in;
   sqrt_type chain [0:SQRT_STAGES];
   side_type side_ff [0:SQRT_STAGES];
   side_type side_in, side_out;
   flag_type flag_ff [0:AT_LAT-1];
   flag_type flag_in, flag_out;

   logic [30:0] ce;
   logic [31:0] el_ang, az_ang, el_sel, az_sel;
   logic [AB-1:0] az_ff, el_ff;
   logic deg_ff;

   assign en         = !vld_ff[LATENCY-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LATENCY-1];
   assign vld_in     = {vld_ff[LATENCY-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         lat_ff <= '0;
      end else begin
         if (en) vld_ff <= vld_in;
         if (csr_we) lat_ff <= csr_wdata;
      end
   end

   assign ra32  = to32(req_tdata[AB-1:0]);
   assign dec32 = to32(req_tdata[2*AB-1:AB]);
   assign lst32 = to32(req_tdata[3*AB-1:2*AB]);
   assign ha32  = lst32 - ra32;

   ete_sincos u_lat (.clock(clock), .en(en), .angle(to32(lat_ff)), .cos_q(cl), .sin_q(sl));
   ete_sincos u_dec (.clock(clock), .en(en), .angle(dec32),        .cos_q(cd), .sin_q(sd));
   ete_sincos u_ha  (.clock(clock), .en(en), .angle(ha32),         .cos_q(ch), .sin_q(sh));

   assign abs_cl = m1_cl_ff[31] ? -m1_cl_ff : m1_cl_ff;
   assign sum_se = 33'(m2_p1_ff) + 33'(m2_p3_ff);
   assign se_sq  = m3_se_ff * m3_se_ff;

   always_comb begin
      if (sum_se > 33'(ONE_Q30)) m3_se_in = ONE_Q30;
      else if (sum_se < -33'(ONE_Q30)) m3_se_in = -ONE_Q30;
      else m3_se_in = sum_se[31:0];
   end

   always_comb begin
      den_in = 34'(m4_sd_ff) - 34'(m4_t_ff);
      if (m4_cl_ff[31]) den_in = -den_in;
      m5_in.v        = (SQ_W'(1) << (SQ_W - 1)) - m4_sq_ff;
      m5_in.res      = '0;
      side_in.se      = m4_se_ff;
      side_in.cl_zero = (m4_cl_ff == 0);
      side_in.num     = m4_num_ff;
      side_in.den     = den_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_p1_ff   <= mulq(sl, sd);
         m1_p2_ff   <= mulq(cd, ch);
         m1_q1_ff   <= mulq(sh, cd);
         m1_sl_ff   <= sl;
         m1_cl_ff   <= cl;
         m1_sd_ff   <= sd;
         m2_p1_ff   <= m1_p1_ff;
         m2_p3_ff   <= mulq(m1_cl_ff, m1_p2_ff);
         m2_numr_ff <= mulq(m1_q1_ff, abs_cl);
         m2_sl_ff   <= m1_sl_ff;
         m2_cl_ff   <= m1_cl_ff;
         m2_sd_ff   <= m1_sd_ff;
         m3_se_ff   <= m3_se_in;
         m3_num_ff  <= -m2_numr_ff;
         m3_sl_ff   <= m2_sl_ff;
         m3_cl_ff   <= m2_cl_ff;
         m3_sd_ff   <= m2_sd_ff;
         m4_sq_ff   <= se_sq[SQ_W-1:0];
         m4_t_ff    <= mulq(m3_se_ff, m3_sl_ff);
         m4_se_ff   <= m3_se_ff;
         m4_cl_ff   <= m3_cl_ff;
         m4_sd_ff   <= m3_sd_ff;
         m4_num_ff  <= m3_num_ff;
         m5_ff      <= m5_in;
         side_ff[0] <= side_in;
         for (int i = 1; i <= SQRT_STAGES; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   assign chain[0] = m5_ff;

   for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
      ete_sqrt_cell #(.STAGE(i)) u_cell (
         .clock (clock),
         .en    (en),
         .d     (chain[i]),
         .q     (chain[i+1])
      );
   end

   assign side_out = side_ff[SQRT_STAGES];
   assign ce       = chain[SQRT_STAGES].res[30:0];

   always_comb begin
      flag_in.ce_zero = (ce == 0);
      flag_in.se_pos  = !side_out.se[31] && (side_out.se != 0);
      flag_in.degen   = (ce == 0) || side_out.cl_zero;
   end

   ete_atan2 u_el (
      .clock (clock),
      .en    (en),
      .x     ({3'b000, ce}),
      .y     (AT_IN_W'(side_out.se)),
      .angle (el_ang)
   );

   ete_atan2 u_az (
      .clock (clock),
      .en    (en),
      .x     (side_out.den),
      .y     (AT_IN_W'(side_out.num)),
      .angle (az_ang)
   );

   assign flag_out = flag_ff[AT_LAT-1];

   always_comb begin
      if (flag_out.ce_zero) el_sel = flag_out.se_pos ? QUARTER_ANG : NEG_QUARTER_ANG;
      else el_sel = el_ang;
      az_sel = flag_out.degen ? 32'h0 : az_ang;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flag_ff[0] <= flag_in;
         for (int i = 1; i < AT_LAT; i++) flag_ff[i] <= flag_ff[i-1];
         az_ff  <= from32(az_sel);
         el_ff  <= from32(el_sel);
         deg_ff <= flag_out.degen;
      end
   end

   assign rsp_tdata    = RSP_W'({el_ff, az_ff});
   assign rsp_tuser[0] = deg_ff;
endmodule
